// ===== hdl/mmpid_pkg.sv =====
// Package for the multi-mode PID controller: field types, request and register
// codes, scaled bounds and the saturation helpers shared by the datapath.
// No dependencies.
`timescale 1ns / 1ps

package mmpid_pkg;

    // Fixed-point format and widths
    localparam int FRAC_BITS   = 16;
    localparam int INTEG_WIDTH = 48;
    localparam int WORD_W      = 32;
    localparam int GAIN_W      = 32;
    localparam int REQ_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int OP_W        = 35;   // widest P/D operand: second difference of the error
    localparam int WIDE_W      = 36;   // headroom for sums of 32-bit values
    localparam int TERM_W      = 48;
    localparam int SUM_W       = TERM_W + 2;
    localparam int INTEG_LO_W  = INTEG_WIDTH / 2;
    localparam int INTEG_HI_W  = INTEG_WIDTH - INTEG_LO_W;
    localparam int PROD_W      = GAIN_W + ((INTEG_WIDTH > OP_W) ? INTEG_WIDTH : OP_W);

    typedef logic signed [WORD_W-1:0]      t_word;
    typedef logic signed [OP_W-1:0]        t_op;
    typedef logic signed [WIDE_W-1:0]      t_wide;
    typedef logic signed [INTEG_WIDTH-1:0] t_integ;
    typedef logic signed [TERM_W-1:0]      t_term;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [PROD_W-1:0]      t_prod;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POS   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INC   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SPEED = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUAL  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam longint WORD_MAX_L = 64'sd2147483647;

    localparam t_term TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
    localparam t_term TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

    localparam t_integ INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    localparam t_integ INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

    // Scaled bounds; the 32-bit range governs where a scaled bound exceeds it
    localparam longint TGT_RAW = 64'sd25 <<< FRAC_BITS;
    localparam longint ERR_RAW = 64'sd10000 <<< FRAC_BITS;
    localparam longint OUT_RAW = 64'sd1000 <<< FRAC_BITS;
    localparam t_word TGT_BOUND = (TGT_RAW > WORD_MAX_L) ? WORD_MAX : t_word'(TGT_RAW);
    localparam t_word ERR_BOUND = (ERR_RAW > WORD_MAX_L) ? WORD_MAX : t_word'(ERR_RAW);
    localparam t_word OUT_BOUND = (OUT_RAW > WORD_MAX_L) ? WORD_MAX : t_word'(OUT_RAW);

    function automatic t_word sat_word(input t_wide v);
        if (v > t_wide'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < t_wide'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return t_word'(v);
    endfunction

    function automatic t_wide clamp_wide(input t_wide v, input t_word b);
        t_wide hi;
        t_wide lo;
        hi = t_wide'(b);
        lo = -hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic t_integ integ_add(input t_integ acc, input t_word e);
        logic signed [INTEG_WIDTH:0] s;
        s = (INTEG_WIDTH+1)'(acc) + (INTEG_WIDTH+1)'(e);
        if (s[INTEG_WIDTH] != s[INTEG_WIDTH-1]) begin
            return s[INTEG_WIDTH] ? INTEG_MIN : INTEG_MAX;
        end
        return s[INTEG_WIDTH-1:0];
    endfunction

    // Floor shift by the fraction bits, then saturate to the term range
    function automatic t_term sat_term(input t_prod v);
        t_prod sh;
        sh = v >>> FRAC_BITS;
        if (!sh[PROD_W-1] && (|sh[PROD_W-2:TERM_W-1])) begin
            return TERM_MAX;
        end else if (sh[PROD_W-1] && !(&sh[PROD_W-2:TERM_W-1])) begin
            return TERM_MIN;
        end
        return sh[TERM_W-1:0];
    endfunction

    function automatic t_word sat_sum(input t_sum v);
        if (v > t_sum'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < t_sum'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return t_word'(v);
    endfunction

endpackage

// ===== hdl/multi_mode_pid_controller_top.sv =====
// Multi-mode PID controller: input register, state update, split multiply, term
// saturation and output register. Uses mmpid_pkg.
// Path: a result passes the input, operand, product, term and output registers in order.
// Throughput: one item per cycle while i_out_stall is low; the controller state updates
// as an item moves from the input register to the operand register.
// Reset (synchronous, active low) zeroes gains and state and marks history stale.
`timescale 1ns / 1ps

module multi_mode_pid_controller_top
    import mmpid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic signed [31:0]   i_measured,
    input  logic signed [31:0]   i_previous_position,
    input  logic signed [31:0]   i_second_measured,
    input  logic signed [31:0]   i_setpoint,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_drive
);

    // Gains
    t_word r_gain_p, r_gain_i, r_gain_d;

    // Controller state
    t_word  r_err_now, r_err_before, r_inc_err, r_inc_last, r_inc_pre;
    t_integ r_integ;
    logic   r_stale;
    t_word  n_err_now, n_err_before, n_inc_err, n_inc_last, n_inc_pre;
    t_integ n_integ;
    logic   n_stale;

    // Stage 1: input register
    logic             r_s1_valid;
    logic [REQ_W-1:0] r_s1_req;
    t_word            r_s1_meas, r_s1_prev, r_s1_meas2, r_s1_sp;

    // Stage 2: operands
    logic   r_s2_valid, r_s2_dual;
    t_op    r_op_p, r_op_d;
    t_integ r_op_i;
    t_op    n_op_p, n_op_d;
    t_integ n_op_i;

    // Stage 3: partial products
    logic                                r_s3_valid, r_s3_dual;
    logic signed [GAIN_W+OP_W-1:0]       r_prod_p, r_prod_d, n_prod_p, n_prod_d;
    logic signed [GAIN_W+INTEG_LO_W:0]   r_prod_i_lo, n_prod_i_lo;
    logic signed [GAIN_W+INTEG_HI_W-1:0] r_prod_i_hi, n_prod_i_hi;
    logic signed [INTEG_LO_W:0]          i_lo_op;
    logic signed [INTEG_HI_W-1:0]        i_hi_op;

    // Stage 4: saturated terms
    logic  r_s4_valid, r_s4_dual;
    t_term r_term_p, r_term_i, r_term_d;
    t_prod full_i;

    // Output register
    logic  r_out_valid;
    t_word r_out_drive, n_out_drive, sum_sat;
    t_sum  term_sum;

    // Stage 1 helpers
    t_wide  meas_w, sum_m, tgt, inc_p, inc_d;
    t_word  pos_err, spd_err, last_base, pre_base, inc_new;
    t_integ pos_integ, spd_integ;

    logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;
    logic in_go, s1_go, s2_go, s3_go, s4_go;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s4_ready  = !r_s4_valid || out_ready;
    assign s3_ready  = !r_s3_valid || s4_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;

    assign in_go = i_in_valid && s1_ready;
    assign s1_go = r_s1_valid && s2_ready;
    assign s2_go = r_s2_valid && s3_ready;
    assign s3_go = r_s3_valid && s4_ready;
    assign s4_go = r_s4_valid && out_ready;

    assign o_in_stall  = !s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_PROP:  r_gain_p <= $signed(i_cfg_data);
                CFG_GAIN_INTEG: r_gain_i <= $signed(i_cfg_data);
                CFG_GAIN_DERIV: r_gain_d <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s4_ready) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_req   <= i_req_type;
            r_s1_meas  <= i_measured;
            r_s1_prev  <= i_previous_position;
            r_s1_meas2 <= i_second_measured;
            r_s1_sp    <= i_setpoint;
        end
    end

    // Mode decode and state update
    always_comb begin
        meas_w    = t_wide'(r_s1_meas);
        pos_err   = sat_word(t_wide'(r_s1_sp) - meas_w);
        pos_integ = integ_add(r_integ, pos_err);
        sum_m     = meas_w + ((r_s1_req == REQ_DUAL) ? t_wide'(r_s1_meas2) : t_wide'(0));
        spd_err   = sat_word(t_wide'(r_s1_sp) - sum_m);
        spd_integ = integ_add(r_integ, spd_err);
        // stale history reads as zero
        last_base = r_stale ? t_word'(0) : r_inc_err;
        pre_base  = r_stale ? t_word'(0) : r_inc_last;
        tgt       = clamp_wide(t_wide'(r_s1_sp), TGT_BOUND);
        inc_new   = t_word'(clamp_wide(tgt - meas_w, ERR_BOUND));
        inc_p     = t_wide'(inc_new) - t_wide'(last_base);
        inc_d     = t_wide'(inc_new) - (t_wide'(last_base) <<< 1) + t_wide'(pre_base);

        n_err_now    = r_err_now;
        n_err_before = r_err_before;
        n_integ      = r_integ;
        n_inc_err    = r_inc_err;
        n_inc_last   = r_inc_last;
        n_inc_pre    = r_inc_pre;
        n_stale      = r_stale;
        n_op_p       = '0;
        n_op_i       = '0;
        n_op_d       = '0;

        case (r_s1_req)
            REQ_CLEAR: begin
                n_err_now = '0;
                n_integ   = '0;
                n_stale   = 1'b1;
            end
            REQ_POS: begin
                n_err_now = pos_err;
                n_integ   = pos_integ;
                n_op_p    = t_op'(pos_err);
                n_op_i    = pos_integ;
                n_op_d    = t_op'(meas_w - t_wide'(r_s1_prev));
            end
            REQ_INC: begin
                n_inc_pre  = pre_base;
                n_inc_last = last_base;
                n_inc_err  = inc_new;
                n_stale    = 1'b0;
                n_err_now  = sat_word(inc_p);
                n_integ    = t_integ'(inc_new);
                n_op_p     = t_op'(inc_p);
                n_op_i     = t_integ'(inc_new);
                n_op_d     = t_op'(inc_d);
            end
            REQ_SPEED, REQ_DUAL: begin
                n_err_before = r_err_now;
                n_err_now    = spd_err;
                n_integ      = spd_integ;
                n_op_p       = t_op'(spd_err);
                n_op_i       = spd_integ;
                n_op_d       = t_op'(t_wide'(spd_err) - t_wide'(r_err_now));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_now    <= '0;
            r_err_before <= '0;
            r_integ      <= '0;
            r_inc_err    <= '0;
            r_inc_last   <= '0;
            r_inc_pre    <= '0;
            r_stale      <= 1'b1;
        end else if (s1_go) begin
            r_err_now    <= n_err_now;
            r_err_before <= n_err_before;
            r_integ      <= n_integ;
            r_inc_err    <= n_inc_err;
            r_inc_last   <= n_inc_last;
            r_inc_pre    <= n_inc_pre;
            r_stale      <= n_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_dual <= (r_s1_req == REQ_DUAL);
            r_op_p    <= n_op_p;
            r_op_i    <= n_op_i;
            r_op_d    <= n_op_d;
        end
    end

    // Integral product split into two halves of the integrator
    assign i_lo_op     = {1'b0, r_op_i[INTEG_LO_W-1:0]};
    assign i_hi_op     = r_op_i[INTEG_WIDTH-1:INTEG_LO_W];
    assign n_prod_p    = r_gain_p * r_op_p;
    assign n_prod_d    = r_gain_d * r_op_d;
    assign n_prod_i_lo = r_gain_i * i_lo_op;
    assign n_prod_i_hi = r_gain_i * i_hi_op;

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s3_dual   <= r_s2_dual;
            r_prod_p    <= n_prod_p;
            r_prod_d    <= n_prod_d;
            r_prod_i_lo <= n_prod_i_lo;
            r_prod_i_hi <= n_prod_i_hi;
        end
    end

    assign full_i = (t_prod'(r_prod_i_hi) <<< INTEG_LO_W) + t_prod'(r_prod_i_lo);

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_s4_dual <= r_s3_dual;
            r_term_p  <= sat_term(t_prod'(r_prod_p));
            r_term_i  <= sat_term(full_i);
            r_term_d  <= sat_term(t_prod'(r_prod_d));
        end
    end

    always_comb begin
        term_sum    = t_sum'(r_term_p) + t_sum'(r_term_i) + t_sum'(r_term_d);
        sum_sat     = sat_sum(term_sum);
        n_out_drive = sum_sat;
        // dual mode: clamp the drive to its output bound
        if (r_s4_dual) begin
            if (sum_sat > OUT_BOUND) begin
                n_out_drive = OUT_BOUND;
            end else if (sum_sat < t_word'(-OUT_BOUND)) begin
                n_out_drive = t_word'(-OUT_BOUND);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_go) begin
            r_out_drive <= n_out_drive;
        end
    end

    // Checks
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_go |=> ($stable(r_integ) && $stable(r_stale) && $stable(r_err_now)))
        else $error("controller state changed without an item");

    a_clear_zero_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_req == REQ_CLEAR) |=> (r_op_p == '0 && r_op_i == '0 && r_op_d == '0))
        else $error("clear item produced non-zero operands");

    a_inc_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_req == REQ_INC) |=> !r_stale)
        else $error("incremental item left history stale");

    a_dual_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s4_go && r_s4_dual) |=>
            (r_out_drive <= OUT_BOUND && r_out_drive >= t_word'(-OUT_BOUND)))
        else $error("dual drive outside its bound");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for multi_mode_pid_controller_top: a queue-fed driver,
// a random-stall receiver and a predictor of the controller state and drive.
// Depends on mmpid_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
    import mmpid_pkg::*;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     SOAK_STEPS   = 20;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     MAX_REPORTS  = 50;
    localparam int     NEAR_SPAN    = 64 << FRAC_BITS;
    localparam int     EDGE_SPAN    = 40 << FRAC_BITS;
    localparam longint TERM_HI      = (64'sd1 <<< (TERM_W - 1)) - 1;
    localparam longint TERM_LO      = -TERM_HI - 1;
    localparam longint ACC_HI       = (64'sd1 <<< (INTEG_WIDTH - 1)) - 1;
    localparam longint ACC_LO       = -ACC_HI - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [REQ_W-1:0]     REQ_LAST  = '1;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        t_word            meas;
        t_word            prev;
        t_word            meas2;
        t_word            sp;
    } t_pid_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [GAIN_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type = '0;
    logic signed [31:0]   i_measured = '0;
    logic signed [31:0]   i_previous_position = '0;
    logic signed [31:0]   i_second_measured = '0;
    logic signed [31:0]   i_setpoint = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [31:0]   o_drive;

    multi_mode_pid_controller_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_req_type          (i_req_type),
        .i_measured          (i_measured),
        .i_previous_position (i_previous_position),
        .i_second_measured   (i_second_measured),
        .i_setpoint          (i_setpoint),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_drive             (o_drive)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted controller state and gains
    longint kp = 0, ki = 0, kd = 0;
    longint err_now = 0, err_before = 0, integ_acc = 0;
    longint err_k = 0, err_k1 = 0, err_k2 = 0;
    bit     history_stale = 1'b1;

    t_pid_cmd cmd_q[$];
    t_word    drive_exp_q[$];
    t_pid_cmd cmd;
    t_word    want;

    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    int  rx_draw = 0;
    int  rx_hold = 0;
    int  hold_epoch = 0;
    int  hold_seen = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    int  items_taken = 0;
    int  results_seen = 0;
    int  gain_sets = 0;
    int  mode_seen[8];

    function automatic longint bound_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint word_sat(input longint v);
        return bound_to(v, longint'(WORD_MIN), longint'(WORD_MAX));
    endfunction

    function automatic longint acc_add(input longint acc, input longint e);
        return bound_to(acc + e, ACC_LO, ACC_HI);
    endfunction

    // Gain times operand, floor-shifted by the fraction bits, held to the term range
    function automatic longint gain_term(input longint g, input longint x);
        logic signed [95:0] prod;
        prod = 96'(g) * 96'(x);
        prod = prod >>> FRAC_BITS;
        if (prod > 96'(TERM_HI)) begin
            return TERM_HI;
        end else if (prod < 96'(TERM_LO)) begin
            return TERM_LO;
        end
        return longint'(prod);
    endfunction

    function automatic longint pid_sum(input longint p, input longint i, input longint d);
        return word_sat(gain_term(kp, p) + gain_term(ki, i) + gain_term(kd, d));
    endfunction

    function automatic t_word predict_drive(input logic [REQ_W-1:0] req, input t_word meas,
                                            input t_word prev, input t_word meas2,
                                            input t_word sp);
        longint m;
        longint tgt;
        longint p;
        longint d;
        longint dr;
        dr = 0;
        case (req)
            REQ_CLEAR: begin
                err_now = 0;
                integ_acc = 0;
                history_stale = 1'b1;
            end
            REQ_POS: begin
                m = meas;
                err_now = word_sat(longint'(sp) - m);
                integ_acc = acc_add(integ_acc, err_now);
                dr = pid_sum(err_now, integ_acc, m - longint'(prev));
            end
            REQ_INC: begin
                if (history_stale) begin
                    err_k = 0;
                    err_k1 = 0;
                    err_k2 = 0;
                    history_stale = 1'b0;
                end
                tgt = bound_to(sp, -longint'(TGT_BOUND), longint'(TGT_BOUND));
                err_k2 = err_k1;
                err_k1 = err_k;
                err_k = word_sat(bound_to(tgt - longint'(meas), -longint'(ERR_BOUND),
                                          longint'(ERR_BOUND)));
                p = err_k - err_k1;
                d = err_k - 2 * err_k1 + err_k2;
                err_now = word_sat(p);
                integ_acc = err_k;
                dr = pid_sum(p, err_k, d);
            end
            REQ_SPEED, REQ_DUAL: begin
                m = meas;
                if (req == REQ_DUAL) begin
                    m = m + longint'(meas2);
                end
                err_before = err_now;
                err_now = word_sat(longint'(sp) - m);
                integ_acc = acc_add(integ_acc, err_now);
                dr = pid_sum(err_now, integ_acc, err_now - err_before);
                if (req == REQ_DUAL) begin
                    dr = bound_to(dr, -longint'(OUT_BOUND), longint'(OUT_BOUND));
                end
            end
            default: begin
            end
        endcase
        return t_word'(dr);
    endfunction

    task automatic load_gain(input logic [CFG_IDX_W-1:0] idx, input t_word val);
        case (idx)
            CFG_GAIN_PROP:  kp = val;
            CFG_GAIN_INTEG: ki = val;
            CFG_GAIN_DERIV: kd = val;
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Driver: present the next item once the bus is free and its gap has run out
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (tx_wait != 0) begin
                tx_wait <= tx_wait - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                cmd = cmd_q.pop_front();
                i_req_type <= cmd.req;
                i_measured <= cmd.meas;
                i_previous_position <= cmd.prev;
                i_second_measured <= cmd.meas2;
                i_setpoint <= cmd.sp;
                i_in_valid <= 1'b1;
                tx_wait <= tx_idle ? int'($urandom_range(0, 19)) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result, plus an occasional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_epoch != hold_seen) begin
            hold_seen <= hold_epoch;
            rx_hold <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            rx_draw = rx_idle ? int'($urandom_range(0, 19)) : 0;
            rx_wait <= rx_draw;
            i_out_stall <= (rx_draw != 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            rx_wait <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: check results first, then follow register writes and accepted items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (drive_exp_q.size() == 0) begin
                    report_mismatch($sformatf("drive %0d with no item outstanding", o_drive));
                end else begin
                    want = drive_exp_q.pop_front();
                    if (o_drive !== want) begin
                        report_mismatch($sformatf("drive %0d, predicted %0d", o_drive, want));
                    end
                end
            end
            if (i_cfg_we) begin
                load_gain(i_cfg_idx, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                mode_seen[i_req_type]++;
                drive_exp_q.push_back(predict_drive(i_req_type, i_measured,
                                                    i_previous_position,
                                                    i_second_measured, i_setpoint));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_word pick_value();
        t_word v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = t_word'(1);
                endcase
            end
            1, 2: v = $signed($urandom);
            3, 4, 5: v = t_word'($urandom_range(0, 2 * NEAR_SPAN)) - t_word'(NEAR_SPAN);
            6: v = ($urandom_range(0, 1) ? TGT_BOUND : -TGT_BOUND)
                   + t_word'($urandom_range(0, 16)) - t_word'(8);
            7: v = ($urandom_range(0, 1) ? ERR_BOUND : -ERR_BOUND)
                   + t_word'($urandom_range(0, 2 * EDGE_SPAN)) - t_word'(EDGE_SPAN);
            default: v = $signed($urandom) >>> $urandom_range(4, 24);
        endcase
        return v;
    endfunction

    function automatic t_word pick_gain();
        t_word v;
        case ($urandom_range(0, 5))
            0: v = WORD_MAX;
            1: v = WORD_MIN;
            2: v = '0;
            3: v = t_word'(1 << FRAC_BITS);
            4: v = $signed($urandom);
            default: v = t_word'($urandom_range(0, 8 << FRAC_BITS)) - t_word'(4 << FRAC_BITS);
        endcase
        return v;
    endfunction

    task automatic add_cmd(input logic [REQ_W-1:0] req, input t_word meas, input t_word prev,
                           input t_word meas2, input t_word sp);
        cmd_q.push_back('{req, meas, prev, meas2, sp});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_gains(input t_word gp, input t_word gi, input t_word gd);
        write_reg(CFG_GAIN_PROP, gp);
        write_reg(CFG_GAIN_INTEG, gi);
        write_reg(CFG_GAIN_DERIV, gd);
        gain_sets++;
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || i_in_valid || drive_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Runs of one mode with random content, some clears and unused codes between
    task automatic queue_random(input int count);
        int n;
        int run;
        int sel;
        logic [REQ_W-1:0] mode;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                mode = REQ_CLEAR;
            end else if (sel < 30) begin
                mode = REQ_POS;
            end else if (sel < 54) begin
                mode = REQ_INC;
            end else if (sel < 74) begin
                mode = REQ_SPEED;
            end else if (sel < 95) begin
                mode = REQ_DUAL;
            end else begin
                mode = REQ_W'($urandom_range(int'(REQ_DUAL) + 1, int'(REQ_LAST)));
            end
            run = (mode == REQ_CLEAR || mode > REQ_DUAL) ? 1 : $urandom_range(1, 12);
            repeat (run) begin
                add_cmd(mode, pick_value(), pick_value(), pick_value(), pick_value());
                n++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Gains still at reset: drive stays zero while the state moves
        add_cmd(REQ_POS, t_word'(1 << FRAC_BITS), '0, '0, t_word'(3 << FRAC_BITS));
        add_cmd(REQ_INC, t_word'(-5), '0, '0, TGT_BOUND);
        wait_drained();

        write_gains(t_word'(1 << FRAC_BITS), t_word'(1 << (FRAC_BITS - 1)),
                    t_word'(1 << (FRAC_BITS - 2)));
        tx_idle <= 1'b1;
        rx_idle <= 1'b1;
        add_cmd(REQ_CLEAR, pick_value(), pick_value(), pick_value(), pick_value());
        add_cmd(REQ_POS, WORD_MIN, WORD_MAX, '0, WORD_MAX);
        add_cmd(REQ_POS, WORD_MAX, WORD_MIN, '0, WORD_MIN);
        add_cmd(REQ_POS, t_word'(-(3 << FRAC_BITS) + 5), t_word'(7), '0,
                t_word'(2 << FRAC_BITS));
        add_cmd(REQ_CLEAR, '0, '0, '0, '0);
        // target and error both clamp, positive then negative
        add_cmd(REQ_INC, WORD_MIN, '0, '0, WORD_MAX);
        add_cmd(REQ_INC, WORD_MAX, '0, '0, WORD_MIN);
        add_cmd(REQ_INC, t_word'(1 << (FRAC_BITS - 1)), '0, '0, TGT_BOUND - t_word'(1));
        add_cmd(REQ_INC, -TGT_BOUND, '0, '0, -TGT_BOUND - t_word'(1));
        add_cmd(REQ_INC, ERR_BOUND, '0, '0, TGT_BOUND);
        add_cmd(REQ_SPEED, WORD_MIN, '0, '0, WORD_MAX);
        add_cmd(REQ_SPEED, WORD_MAX, '0, '0, WORD_MIN);
        add_cmd(REQ_DUAL, WORD_MAX, '0, WORD_MAX, WORD_MIN);
        add_cmd(REQ_DUAL, WORD_MIN, '0, WORD_MIN, WORD_MAX);
        add_cmd(REQ_DUAL, t_word'(10 << FRAC_BITS), '0, t_word'(-(3 << FRAC_BITS)),
                t_word'(20 << FRAC_BITS));
        add_cmd(REQ_DUAL + 3'd1, pick_value(), pick_value(), pick_value(), pick_value());
        add_cmd(REQ_DUAL + 3'd2, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        add_cmd(REQ_LAST, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        add_cmd(REQ_INC, t_word'(2 << FRAC_BITS), '0, '0, '0);
        add_cmd(REQ_CLEAR, '0, '0, '0, '0);
        add_cmd(REQ_INC, t_word'(-(2 << FRAC_BITS)), '0, '0, '0);
        wait_drained();

        // Integrator soak: runs of the largest error each way, then step back off
        write_gains('0, t_word'(1), '0);
        tx_idle <= 1'b0;
        rx_idle <= 1'b0;
        repeat (SOAK_STEPS) add_cmd(REQ_POS, WORD_MIN, WORD_MIN, '0, WORD_MAX);
        repeat (20) add_cmd(REQ_POS, WORD_MAX, WORD_MAX, '0, '0);
        add_cmd(REQ_CLEAR, '0, '0, '0, '0);
        repeat (SOAK_STEPS) add_cmd(REQ_SPEED, WORD_MAX, '0, '0, WORD_MIN);
        repeat (20) add_cmd(REQ_SPEED, WORD_MIN, '0, '0, '0);
        wait_drained();

        for (int k = 0; k < 8; k++) begin
            case (k)
                1: write_gains(WORD_MAX, WORD_MAX, WORD_MAX);
                3: write_gains(WORD_MIN, WORD_MIN, WORD_MIN);
                4: write_gains('0, WORD_MAX, WORD_MIN);
                default: write_gains(pick_gain(), pick_gain(), pick_gain());
            endcase
            if (k == 5) begin
                write_reg(CFG_SPARE, $signed($urandom));
            end
            if (k == 2) begin
                // hold the output while the sender keeps pushing
                tx_idle <= 1'b0;
                rx_idle <= 1'b0;
                hold_epoch <= hold_epoch + 1;
            end else begin
                tx_idle <= (k < 2) || ($urandom_range(0, 2) != 0);
                rx_idle <= (k < 2) || ($urandom_range(0, 2) != 0);
            end
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("Run covered %0d items: %0d clear, %0d positional, %0d incremental, %0d speed,",
                 items_taken, mode_seen[REQ_CLEAR], mode_seen[REQ_POS], mode_seen[REQ_INC],
                 mode_seen[REQ_SPEED]);
        $display("%0d dual, %0d unused codes; %0d drives checked over %0d gain settings.",
                 mode_seen[REQ_DUAL], items_taken - mode_seen[REQ_CLEAR] - mode_seen[REQ_POS]
                 - mode_seen[REQ_INC] - mode_seen[REQ_SPEED] - mode_seen[REQ_DUAL],
                 results_seen, gain_sets);
        if (err_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
